FILE: rtl/assert_macros.svh
// Assertion macros shared by the double-precision shift unit RTL.
// Needs clk and rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define DPSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define DPSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dpsu_pkg.sv
// Types, constants and helper functions for the double-precision shift unit.
// No dependencies; used by dpsu_flag_calc and double_precision_shift_unit.
package dpsu_pkg;

  localparam logic KIND_SHL = 1'b0;
  localparam logic KIND_SHR = 1'b1;

  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_32 = 2'd1;

  localparam logic [5:0] CNT_MASK_WIDE   = 6'd63;
  localparam logic [5:0] CNT_MASK_NARROW = 6'd31;
  localparam logic [5:0] CNT_LIMIT_16    = 6'd16;
  localparam logic [5:0] CNT_ONE         = 6'd1;

  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 1;
  localparam int FLAG_ZF = 2;
  localparam int FLAG_SF = 3;
  localparam int FLAG_OF = 4;

  typedef enum logic [1:0] {
    WIDTH_16,
    WIDTH_32,
    WIDTH_64
  } width_t;

  // Per-item control carried down the pipe
  typedef struct packed {
    logic        kind;
    width_t      width;
    logic [5:0]  cnt;
    logic        skip;
    logic [63:0] dest;
    logic [4:0]  flags;
  } ctl_t;

  // Shifter output handed to the flag stage
  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] res;
    logic        cf;
  } shres_t;

  function automatic logic [63:0] rev64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = x[63-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/double_precision_shift_unit.sv
// Double-precision shift unit (SHLD/SHRD) top level: four-stage pipeline.
// Depends on dpsu_pkg, dpsu_flag_calc and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries one shift operation per transfer:
//   direction, operand size, destination, fill operand, raw count, flags.
//   Output channel out_valid/out_ready returns one result per operation, in
//   order: shifted value (zero above the operand size), flags, changed bit.
//   Order: each operation passes the registered stages align, byte shift,
//   bit shift and flags; out_valid rises once it sits in the output register.
//   Throughput: one operation per cycle unless stalled; the 129-bit funnel
//   shift spans two stages, each a 3-level mux shifter (byte, then bit steps).
//   Stalls: each stage advances when the stage after it is empty or moving;
//   a stalled out_ready holds the output register and backs up the pipe
//   one stage at a time, so empty stages keep accepting input.
//   in_ready falls only when all four stages hold items.
//   Reset (rst_n low, synchronous) empties every stage; no item is lost or
//   replayed across a stall.
`include "assert_macros.svh"

module double_precision_shift_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_dest_value,
  input  logic [63:0] in_fill_value,
  input  logic [7:0]  in_count_raw,
  input  logic [4:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic [4:0]  out_flags_out,
  output logic        out_changed
);

  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic adv1, adv2, adv3, adv4;

  dpsu_pkg::ctl_t   s1_ctl_r, s1_ctl_nxt, s2_ctl_r;
  logic [127:0]     s1_vec_r, s1_vec_nxt;
  logic [128:0]     s2_vec_r, s2_vec_nxt;
  dpsu_pkg::shres_t s3_r, s3_nxt;

  logic [63:0] out_result_r, out_result_nxt;
  logic [4:0]  out_flags_r, out_flags_nxt;
  logic        out_changed_r, out_changed_nxt;

  // Handshake
  assign adv4     = !out_vld_r || out_ready;
  assign adv3     = !s3_vld_r || adv4;
  assign adv2     = !s2_vld_r || adv3;
  assign adv1     = !s1_vld_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r <= in_valid;
      if (adv2) s2_vld_r <= s1_vld_r;
      if (adv3) s3_vld_r <= s2_vld_r;
      if (adv4) out_vld_r <= s3_vld_r;
    end
  end

  // Stage 1: mask operands and count, build left-justified funnel word
  logic [63:0] dm, sm, dr, sr;
  logic [5:0]  cnt;
  dpsu_pkg::width_t width;

  always_comb begin
    case (in_size_code)
      dpsu_pkg::SIZE_16: width = dpsu_pkg::WIDTH_16;
      dpsu_pkg::SIZE_32: width = dpsu_pkg::WIDTH_32;
      default:           width = dpsu_pkg::WIDTH_64;
    endcase

    case (width)
      dpsu_pkg::WIDTH_16: begin
        dm = {48'd0, in_dest_value[15:0]};
        sm = {48'd0, in_fill_value[15:0]};
      end
      dpsu_pkg::WIDTH_32: begin
        dm = {32'd0, in_dest_value[31:0]};
        sm = {32'd0, in_fill_value[31:0]};
      end
      default: begin
        dm = in_dest_value;
        sm = in_fill_value;
      end
    endcase

    cnt = (width == dpsu_pkg::WIDTH_64) ? (in_count_raw[5:0] & dpsu_pkg::CNT_MASK_WIDE)
                                        : (in_count_raw[5:0] & dpsu_pkg::CNT_MASK_NARROW);

    // Right shifts run as left shifts on bit-reversed operands
    dr = dpsu_pkg::rev64(dm);
    sr = dpsu_pkg::rev64(sm);

    case (width)
      dpsu_pkg::WIDTH_16: begin
        if (in_kind == dpsu_pkg::KIND_SHR) s1_vec_nxt = {dr[63:48], sr[63:48], 96'd0};
        else                               s1_vec_nxt = {dm[15:0], sm[15:0], 96'd0};
      end
      dpsu_pkg::WIDTH_32: begin
        if (in_kind == dpsu_pkg::KIND_SHR) s1_vec_nxt = {dr[63:32], sr[63:32], 64'd0};
        else                               s1_vec_nxt = {dm[31:0], sm[31:0], 64'd0};
      end
      default: begin
        if (in_kind == dpsu_pkg::KIND_SHR) s1_vec_nxt = {dr, sr};
        else                               s1_vec_nxt = {dm, sm};
      end
    endcase

    s1_ctl_nxt.kind  = in_kind;
    s1_ctl_nxt.width = width;
    s1_ctl_nxt.cnt   = cnt;
    s1_ctl_nxt.skip  = (cnt == 6'd0) ||
                       ((width == dpsu_pkg::WIDTH_16) && (cnt > dpsu_pkg::CNT_LIMIT_16));
    s1_ctl_nxt.dest  = dm;
    s1_ctl_nxt.flags = in_flags_in;
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_vec_r <= s1_vec_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // Stage 2: shift by whole bytes; bit 128 catches the carry-out
  assign s2_vec_nxt = {1'b0, s1_vec_r} << {s1_ctl_r.cnt[5:3], 3'b000};

  always_ff @(posedge clk) begin
    if (adv2 && s1_vld_r) begin
      s2_vec_r <= s2_vec_nxt;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // Stage 3: shift by remaining bits, extract result and CF
  logic [128:0] p3;
  logic [63:0]  f3, f3r;

  always_comb begin
    p3  = s2_vec_r << s2_ctl_r.cnt[2:0];
    f3  = p3[127:64];
    f3r = dpsu_pkg::rev64(f3);
    s3_nxt.ctl = s2_ctl_r;
    s3_nxt.cf  = p3[128];
    case (s2_ctl_r.width)
      dpsu_pkg::WIDTH_16: begin
        if (s2_ctl_r.kind == dpsu_pkg::KIND_SHR) s3_nxt.res = {48'd0, f3r[15:0]};
        else                                     s3_nxt.res = {48'd0, f3[63:48]};
      end
      dpsu_pkg::WIDTH_32: begin
        if (s2_ctl_r.kind == dpsu_pkg::KIND_SHR) s3_nxt.res = {32'd0, f3r[31:0]};
        else                                     s3_nxt.res = {32'd0, f3[63:32]};
      end
      default: begin
        if (s2_ctl_r.kind == dpsu_pkg::KIND_SHR) s3_nxt.res = f3r;
        else                                     s3_nxt.res = f3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_vld_r) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: flags, into the output register
  dpsu_flag_calc u_flag_calc (
    .sh           (s3_r),
    .result_value (out_result_nxt),
    .flags_out    (out_flags_nxt),
    .changed      (out_changed_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv4 && s3_vld_r) begin
      out_result_r  <= out_result_nxt;
      out_flags_r   <= out_flags_nxt;
      out_changed_r <= out_changed_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_value = out_result_r;
  assign out_flags_out    = out_flags_r;
  assign out_changed      = out_changed_r;

  `DPSU_ASSERT_IMP(a_full_stall, !in_ready,
    s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && !out_ready,
    "input blocked while pipe has room")
  `DPSU_ASSERT_IMP(a_zf_match, out_valid && out_changed,
    out_flags_out[dpsu_pkg::FLAG_ZF] == (out_result_value == 64'd0),
    "ZF disagrees with result")
  `DPSU_ASSERT_IMP(a_pf_match, out_valid && out_changed,
    out_flags_out[dpsu_pkg::FLAG_PF] == ~^out_result_value[7:0],
    "PF disagrees with result")
  `DPSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_result_value) && $stable(out_flags_out) && $stable(out_changed),
    "result changed while stalled")

endmodule

FILE: rtl/dpsu_flag_calc.sv
// Final stage logic: flag generation and unchanged-operand bypass.
// Depends on dpsu_pkg.
module dpsu_flag_calc (
  input  dpsu_pkg::shres_t sh,
  output logic [63:0]      result_value,
  output logic [4:0]       flags_out,
  output logic             changed
);

  logic msb;
  logic orig_msb;
  logic of;
  logic [4:0] fl;

  always_comb begin
    case (sh.ctl.width)
      dpsu_pkg::WIDTH_16: begin
        msb      = sh.res[15];
        orig_msb = sh.ctl.dest[15];
      end
      dpsu_pkg::WIDTH_32: begin
        msb      = sh.res[31];
        orig_msb = sh.ctl.dest[31];
      end
      default: begin
        msb      = sh.res[63];
        orig_msb = sh.ctl.dest[63];
      end
    endcase

    of = (sh.ctl.kind == dpsu_pkg::KIND_SHR) ? (msb ^ orig_msb) : (msb ^ sh.cf);

    fl                   = '0;
    fl[dpsu_pkg::FLAG_CF] = sh.cf;
    fl[dpsu_pkg::FLAG_PF] = ~^sh.res[7:0];
    fl[dpsu_pkg::FLAG_ZF] = (sh.res == 64'd0);
    fl[dpsu_pkg::FLAG_SF] = msb;
    fl[dpsu_pkg::FLAG_OF] = (sh.ctl.cnt == dpsu_pkg::CNT_ONE) && of;

    if (sh.ctl.skip) begin
      result_value = sh.ctl.dest;
      flags_out    = sh.ctl.flags;
      changed      = 1'b0;
    end else begin
      result_value = sh.res;
      flags_out    = fl;
      changed      = 1'b1;
    end
  end

endmodule

FILE: tb/shift_result_checker.sv
// Checker for the double-precision shift unit: predicts SHLD/SHRD results and compares them.
// It watches both valid/ready channels and hands a failure count to the testbench top.
// Depends on dpsu_pkg for the direction, size, count and flag constants.
module shift_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_dest_value,
  input  logic [63:0] in_fill_value,
  input  logic [7:0]  in_count_raw,
  input  logic [4:0]  in_flags_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_value,
  input  logic [4:0]  out_flags_out,
  input  logic        out_changed,
  output int          err_count,
  output int          pending,
  output int          n_checked,
  output int          n_changed
);

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  flags;
    logic        changed;
  } shift_res_t;

  shift_res_t predicted_shifts[$];

  function automatic shift_res_t predict_shift(
    input logic        kind,
    input logic [1:0]  size_code,
    input logic [63:0] dest,
    input logic [63:0] fill,
    input logic [7:0]  count_raw,
    input logic [4:0]  flags_in
  );
    int unsigned  w;
    logic [63:0]  mask;
    logic [5:0]   cnt;
    logic [127:0] funnel;
    logic [63:0]  res;
    logic         cf;
    logic         sf;
    logic         orig_msb;
    shift_res_t   r;
    case (size_code)
      dpsu_pkg::SIZE_16: w = 16;
      dpsu_pkg::SIZE_32: w = 32;
      default:           w = 64;
    endcase
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    dest = dest & mask;
    fill = fill & mask;
    cnt  = count_raw[5:0] &
           ((w == 64) ? dpsu_pkg::CNT_MASK_WIDE : dpsu_pkg::CNT_MASK_NARROW);
    if (cnt == 6'd0 || (w == 16 && cnt > dpsu_pkg::CNT_LIMIT_16)) begin
      r.value   = dest;
      r.flags   = flags_in;
      r.changed = 1'b0;
      return r;
    end
    orig_msb = dest[w-1];
    if (kind == dpsu_pkg::KIND_SHR) begin
      // fill sits above dest; low bits of the funnel come out
      funnel = ({64'd0, fill} << w) | {64'd0, dest};
      funnel = funnel >> cnt;
      res    = funnel[63:0] & mask;
      cf     = dest[cnt-1];
    end else begin
      // dest sits above fill; window of w bits above the fill comes out
      funnel = ({64'd0, dest} << w) | {64'd0, fill};
      funnel = funnel << cnt;
      res    = funnel[w +: 64] & mask;
      cf     = dest[w-cnt];
    end
    sf = res[w-1];
    r.value                    = res;
    r.flags                    = '0;
    r.flags[dpsu_pkg::FLAG_CF] = cf;
    r.flags[dpsu_pkg::FLAG_PF] = ~^res[7:0];
    r.flags[dpsu_pkg::FLAG_ZF] = (res == 64'd0);
    r.flags[dpsu_pkg::FLAG_SF] = sf;
    if (cnt == dpsu_pkg::CNT_ONE) begin
      r.flags[dpsu_pkg::FLAG_OF] = (kind == dpsu_pkg::KIND_SHR) ? (sf ^ orig_msb) : (sf ^ cf);
    end
    r.changed = 1'b1;
    return r;
  endfunction

  initial begin
    err_count = 0;
    pending   = 0;
    n_checked = 0;
    n_changed = 0;
  end

  always @(posedge clk) begin
    shift_res_t want;
    if (!rst_n) begin
      predicted_shifts.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted_shifts.push_back(predict_shift(in_kind, in_size_code, in_dest_value,
                                                 in_fill_value, in_count_raw, in_flags_in));
      end
      if (out_valid && out_ready) begin
        if (predicted_shifts.size() == 0) begin
          $error("result transfer with no operation outstanding: value %h flags %b",
                 out_result_value, out_flags_out);
          err_count++;
        end else begin
          want = predicted_shifts.pop_front();
          n_checked++;
          if (want.changed) n_changed++;
          if (out_result_value !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, out_result_value);
            err_count++;
          end
          if (out_flags_out !== want.flags) begin
            $error("flags_out: expected %b, got %b", want.flags, out_flags_out);
            err_count++;
          end
          if (out_changed !== want.changed) begin
            $error("changed: expected %b, got %b", want.changed, out_changed);
            err_count++;
          end
        end
      end
    end
    pending = predicted_shifts.size();
  end

endmodule

FILE: tb/double_precision_shift_unit_tb.sv
// Testbench top for double_precision_shift_unit: clock, reset, stimulus and verdict.
// Drives directed then random SHLD/SHRD operations with bursty input and stalling output.
// Depends on dpsu_pkg, the RTL top and shift_result_checker.
module double_precision_shift_unit_tb;

  localparam logic [1:0] SIZE_64     = 2'd2;
  localparam logic [1:0] SIZE_UNUSED = 2'd3;
  localparam int         N_RANDOM    = 700;
  localparam int         HOLD_CYCLES = 60;
  localparam int         CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [1:0]  in_size_code = '0;
  logic [63:0] in_dest_value = '0;
  logic [63:0] in_fill_value = '0;
  logic [7:0]  in_count_raw = '0;
  logic [4:0]  in_flags_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_value;
  logic [4:0]  out_flags_out;
  logic        out_changed;

  int err_count;
  int pending;
  int n_checked;
  int n_changed;
  int n_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;

  always #5 clk = ~clk;

  double_precision_shift_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_size_code     (in_size_code),
    .in_dest_value    (in_dest_value),
    .in_fill_value    (in_fill_value),
    .in_count_raw     (in_count_raw),
    .in_flags_in      (in_flags_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_flags_out    (out_flags_out),
    .out_changed      (out_changed)
  );

  shift_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_size_code     (in_size_code),
    .in_dest_value    (in_dest_value),
    .in_fill_value    (in_fill_value),
    .in_count_raw     (in_count_raw),
    .in_flags_in      (in_flags_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_flags_out    (out_flags_out),
    .out_changed      (out_changed),
    .err_count        (err_count),
    .pending          (pending),
    .n_checked        (n_checked),
    .n_changed        (n_changed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: rotating stall modes, plus one long hold-off to back the pipe up
  initial begin
    int unsigned rcyc;
    rcyc = 0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        rcyc++;
        case ((rcyc / 48) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((rcyc % 5) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_shift(
    input logic        kind,
    input logic [1:0]  size_code,
    input logic [63:0] dest,
    input logic [63:0] fill,
    input logic [7:0]  count_raw,
    input logic [4:0]  flags
  );
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_size_code  <= size_code;
    in_dest_value <= dest;
    in_fill_value <= fill;
    in_count_raw  <= count_raw;
    in_flags_in   <= flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    // keep offering back to back while the receiver is held off
    if (burst_left > 0) begin
      burst_left--;
    end else if (!(long_hold && !hold_done)) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      4: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int          n_directed;
    int unsigned w;
    logic        kind;
    logic [1:0]  size_code;
    logic [7:0]  count_raw;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: count edges per size, masking, 16-bit over-range, count of one, spare size
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_1234,
               64'h0000_0000_0000_5678, 8'd0, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_8000,
               64'h0, 8'd1, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_0001,
               64'h0000_0000_0000_0001, 8'd1, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_A5A5,
               64'h0000_0000_0000_3C3C, 8'd16, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_A5A5,
               64'h0000_0000_0000_3C3C, 8'd16, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_FFFF,
               64'h0, 8'd17, 5'h0A);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_16, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h0, 8'd31, 5'h15);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_00FF,
               64'hFFFF, 8'd32, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_16, 64'h0000_0000_0000_FFFF,
               64'h0, 8'd16, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_32, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h0, 8'd31, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_32, 64'h0000_0000_8000_0000,
               64'h0, 8'd1, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_32, 64'h0000_0000_0000_0001,
               64'h0, 8'd1, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_32, 64'h1234_5678_9ABC_DEF0,
               64'h0, 8'd32, 5'h07);
    send_shift(dpsu_pkg::KIND_SHL, dpsu_pkg::SIZE_32, 64'hFFFF_FFFF_0000_0F0F,
               64'hFFFF_FFFF_F000_0000, 8'd4, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, SIZE_64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd63, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, SIZE_64, 64'h8000_0000_0000_0001,
               64'hFFFF_FFFF_FFFF_FFFF, 8'd63, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, SIZE_64, 64'hDEAD_BEEF_CAFE_F00D,
               64'h0123_4567_89AB_CDEF, 8'd64, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHR, SIZE_64, 64'h0F0F_0F0F_0F0F_0F0F,
               64'hF0F0_F0F0_F0F0_F0F0, 8'd255, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, SIZE_64, 64'h4000_0000_0000_0000, 64'h0, 8'd1, 5'h00);
    send_shift(dpsu_pkg::KIND_SHL, SIZE_64, 64'h0, 64'h0, 8'd5, 5'h1F);
    send_shift(dpsu_pkg::KIND_SHL, SIZE_UNUSED, 64'h8123_4567_89AB_CDEF,
               64'hFEDC_BA98_7654_3210, 8'd8, 5'h00);
    send_shift(dpsu_pkg::KIND_SHR, SIZE_UNUSED, 64'h8123_4567_89AB_CDEF,
               64'h0, 8'd0, 5'h1B);
    send_shift(dpsu_pkg::KIND_SHR, dpsu_pkg::SIZE_16, 64'hABCD_EF01_2345_8001,
               64'h5555_AAAA_FFFF_00FF, 8'd8, 5'h00);
    n_directed = n_sent;
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 500) drain_results();
      kind = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:      size_code = dpsu_pkg::SIZE_16;
        6, 7, 8, 9, 10, 11:    size_code = dpsu_pkg::SIZE_32;
        19:                    size_code = SIZE_UNUSED;
        default:               size_code = SIZE_64;
      endcase
      w = (size_code == dpsu_pkg::SIZE_16) ? 16 : (size_code == dpsu_pkg::SIZE_32) ? 32 : 64;
      case ($urandom_range(0, 9))
        0, 1, 2:  count_raw = 8'($urandom_range(0, 255));
        3:        count_raw = 8'(dpsu_pkg::CNT_ONE);
        default:  count_raw = 8'($urandom_range(0, w + 2));
      endcase
      send_shift(kind, size_code, rand_operand(), rand_operand(), count_raw,
                 5'($urandom_range(0, 31)));
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d shift operations (%0d directed, rest random) over %0d cycles.",
             n_sent, n_directed, cycle_count);
    $display("Checked %0d results: %0d shifted, %0d passed through unchanged.",
             n_checked, n_changed, n_checked - n_changed);
    if (err_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dpsu_pkg.sv
rtl/dpsu_flag_calc.sv
rtl/double_precision_shift_unit.sv
tb/shift_result_checker.sv
tb/double_precision_shift_unit_tb.sv
